/* rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants for the URL percent decoder
// Holds the channel beat layouts, the front-to-back command format, the
// escape tracking codes and the hex digit helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

   // Default depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Characters that the decoder recognizes.
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h66;
   localparam logic [3:0] HEX_TEN    = 4'd10;

   // Number of decoded byte slots in one command.
   localparam int MAX_EMIT = 3;

   // Escape tracking: nothing held, '%' held, or '%' and one digit held.
   typedef enum logic [1:0] {
      PEND_NONE    = 2'd0,
      PEND_PERCENT = 2'd1,
      PEND_DIGIT   = 2'd2
   } upd_pend_type;

   // Input beat.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } upd_req_type;

   // Result beat.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } upd_rsp_type;

   // One classified input byte: the bytes it emits, in order from entry 0.
   typedef struct packed {
      logic [1:0]                   count;
      logic [MAX_EMIT-1:0][7:0]     bytes;
      logic                         last;
   } upd_cmd_type;

   // Queue status seen by front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } upd_queue_status_type;

   // True when the character is a hex digit of either case.
   function automatic logic hex_valid(input logic [7:0] c);
      hex_valid = (c inside {[CH_0:CH_9], [CH_UA:CH_UF], [CH_LA:CH_LF]});
   endfunction

   // Value of a hex digit character; zero for anything else.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'd0;
      if (c inside {[CH_0:CH_9]}) begin
         diff = c - CH_0;
         hex_value = diff[3:0];
      end else if (c inside {[CH_UA:CH_UF]}) begin
         diff = c - CH_UA;
         hex_value = HEX_TEN + diff[3:0];
      end else if (c inside {[CH_LA:CH_LF]}) begin
         diff = c - CH_LA;
         hex_value = HEX_TEN + diff[3:0];
      end else begin
         hex_value = 4'd0;
      end
   endfunction

endpackage

/* rtl/upd_stream_if.sv */
// ----------------------------------------------------------------------------
// upd_stream_if: valid/ready stream channel
// Carries one beat of a typed payload; a beat moves on a clock edge at which
// valid and ready are both high.
// ----------------------------------------------------------------------------
interface upd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/upd_front.sv */
// ----------------------------------------------------------------------------
// upd_front: input side of the URL percent decoder
// Accepts raw bytes, tracks pending escapes and turns each byte into a
// command listing the zero to three decoded bytes it produces.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   upd_stream_if.sink           req_bus,
   input  upd_queue_status_type queue_status,
   output logic                 push,
   output upd_cmd_type          push_cmd
);

   upd_pend_type pend_ff, pend_in;
   logic [7:0]   digit_ff, digit_in;
   logic [3:0]   nibble_ff, nibble_in;

   logic [7:0]              cur_byte;
   logic                    cur_last;
   logic                    cur_hex;
   logic [3:0]              cur_val;
   logic                    fresh;
   logic [1:0]              emit_count;
   logic [MAX_EMIT-1:0][7:0] emit_bytes;
   logic                    accept;

   assign cur_byte = req_bus.payload.in_byte;
   assign cur_last = req_bus.payload.in_last;
   assign cur_hex  = hex_valid(cur_byte);
   assign cur_val  = hex_value(cur_byte);

   // Accept whenever the queue has room for a command.
   assign req_bus.ready = !queue_status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Classify the byte against the held escape and list the bytes it emits.
   always_comb begin
      pend_in    = pend_ff;
      digit_in   = digit_ff;
      nibble_in  = nibble_ff;
      emit_bytes = '0;
      emit_count = 2'd0;
      fresh      = 1'b0;

      case (pend_ff)
         PEND_PERCENT: begin
            if (cur_hex) begin
               pend_in   = PEND_DIGIT;
               digit_in  = cur_byte;
               nibble_in = cur_val;
            end else begin
               emit_bytes[emit_count] = CH_PERCENT;
               emit_count = emit_count + 2'd1;
               fresh = 1'b1;
            end
         end
         PEND_DIGIT: begin
            if (cur_hex) begin
               emit_bytes[emit_count] = {nibble_ff, cur_val};
               emit_count = emit_count + 2'd1;
               pend_in = PEND_NONE;
            end else begin
               emit_bytes[emit_count] = CH_PERCENT;
               emit_count = emit_count + 2'd1;
               emit_bytes[emit_count] = digit_ff;
               emit_count = emit_count + 2'd1;
               fresh = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      // A broken escape or an idle tracker decodes the byte afresh.
      if (fresh) begin
         pend_in = PEND_NONE;
         if (cur_byte == CH_PERCENT) begin
            pend_in = PEND_PERCENT;
         end else begin
            emit_bytes[emit_count] = (cur_byte == CH_PLUS) ? CH_SPACE : cur_byte;
            emit_count = emit_count + 2'd1;
         end
      end

      // At the end of the string anything still held goes out literally.
      if (cur_last) begin
         if (pend_in == PEND_PERCENT) begin
            emit_bytes[emit_count] = CH_PERCENT;
            emit_count = emit_count + 2'd1;
         end else if (pend_in == PEND_DIGIT) begin
            emit_bytes[emit_count] = CH_PERCENT;
            emit_count = emit_count + 2'd1;
            emit_bytes[emit_count] = digit_in;
            emit_count = emit_count + 2'd1;
         end
         pend_in   = PEND_NONE;
         digit_in  = 8'd0;
         nibble_in = 4'd0;
      end
   end

   // Bytes that emit nothing are not queued.
   assign push           = accept && (emit_count != 2'd0);
   assign push_cmd.count = emit_count;
   assign push_cmd.bytes = emit_bytes;
   assign push_cmd.last  = cur_last;

   // Escape tracking registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= PEND_NONE;
         digit_ff  <= 8'd0;
         nibble_ff <= 4'd0;
      end else if (accept) begin
         pend_ff   <= pend_in;
         digit_ff  <= digit_in;
         nibble_ff <= nibble_in;
      end
   end

endmodule

/* rtl/upd_queue.sv */
// ----------------------------------------------------------------------------
// upd_queue: command queue between front and back
// A small register FIFO that lets the front keep accepting bytes while the
// back is still emitting earlier commands.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  upd_cmd_type          push_cmd,
   input  logic                 pop,
   output upd_cmd_type          head_cmd,
   output upd_queue_status_type status
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int LevelWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(Depth - 1);
   localparam logic [LevelWidth-1:0] LevelFull = LevelWidth'(Depth);

   upd_cmd_type             entry_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LevelWidth-1:0]   level_ff, level_in;

   assign status.full  = (level_ff == LevelFull);
   assign status.empty = (level_ff == '0);
   assign head_cmd     = entry_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/upd_back.sv */
// ----------------------------------------------------------------------------
// upd_back: output side of the URL percent decoder
// Walks through the bytes of the command at the queue head, one per cycle,
// into an output register that holds while the consumer stalls.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  upd_cmd_type          head_cmd,
   input  upd_queue_status_type queue_status,
   output logic                 pop,
   upd_stream_if.source         rsp_bus
);

   logic [1:0]  index_ff, index_in;
   logic        valid_ff, valid_in;
   upd_rsp_type beat_ff, beat_in;
   logic        load;
   logic        final_byte;

   // The output register takes a new beat when empty or being drained.
   assign load       = !valid_ff || rsp_bus.ready;
   assign final_byte = (index_ff == head_cmd.count - 2'd1);
   assign pop        = load && !queue_status.empty && final_byte;

   always_comb begin
      index_in = index_ff;
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = !queue_status.empty;
         if (!queue_status.empty) begin
            beat_in.out_byte   = head_cmd.bytes[index_ff];
            beat_in.run_last   = final_byte;
            beat_in.string_end = final_byte && head_cmd.last;
            index_in = final_byte ? 2'd0 : index_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp_bus.valid   = valid_ff;
   assign rsp_bus.payload = beat_ff;

endmodule

/* rtl/url_percent_decoder.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes %XX escapes and '+' into bytes, one raw byte per input beat.
//
//   channel   dir   beat contents                    handshake
//   req_bus   in    in_byte, in_last                 valid/ready
//   rsp_bus   out   out_byte, run_last, string_end   valid/ready
//
// An input beat is classified in the cycle it is accepted and, if it emits
// anything, queued as a command of one to three bytes. While rsp_bus is ready,
// the back emits one result beat per cycle and input moves at one beat per
// cycle if each byte yields at most one result; a byte with more holds the
// back until all are out. Results go via a queue entry and the output register.
// Reset is synchronous and clears escape tracking, queue and output register.
// A stalled result side fills the queue, after which req_bus.ready drops.
// ----------------------------------------------------------------------------
module url_percent_decoder import upd_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   upd_stream_if.sink   req_bus,
   upd_stream_if.source rsp_bus
);

   upd_queue_status_type queue_status;
   upd_cmd_type          push_cmd;
   upd_cmd_type          head_cmd;
   logic                 push;
   logic                 pop;

   upd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .queue_status (queue_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   upd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   upd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );

endmodule

/* tb/sv/upd_decode_checker.sv */
// ----------------------------------------------------------------------------
// upd_decode_checker: result predictor and scoreboard for the URL decoder
// Watches both channels. Each accepted input beat is decoded here into the
// result beats that the decoder must produce. Each accepted result beat is
// compared field by field against the oldest result still due.
// ----------------------------------------------------------------------------
module upd_decode_checker import upd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  upd_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  upd_rsp_type rsp_payload,
   output int          error_count,
   output int          results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // Escape tracking of the predicted decoder.
   upd_pend_type escape_state;
   logic [7:0]   held_digit;
   logic [3:0]   held_nibble;

   // Decoded beats that the decoder still owes, oldest first.
   upd_rsp_type  due_beats[$];

   initial begin
      error_count = 0;
      results_due = 0;
      escape_state = PEND_NONE;
      held_digit = 8'd0;
      held_nibble = 4'd0;
   end

   always @(posedge clock) begin : watch_channels
      logic [7:0]  raw;
      logic        is_final;
      logic        is_digit;
      logic        redo;
      logic [3:0]  nibble;
      logic [7:0]  decoded[$];
      upd_rsp_type beat;
      upd_rsp_type want;

      if (reset) begin
         escape_state = PEND_NONE;
         held_digit = 8'd0;
         held_nibble = 4'd0;
         due_beats.delete();
      end else begin
         // Decode an accepted input beat into the bytes it releases.
         if (req_valid && req_ready) begin
            raw = req_payload.in_byte;
            is_final = req_payload.in_last;
            decoded.delete();
            redo = 1'b0;
            is_digit = 1'b1;
            nibble = 4'd0;
            if (raw >= CH_0 && raw <= CH_9) begin
               nibble = 4'(raw - CH_0);
            end else if (raw >= CH_UA && raw <= CH_UF) begin
               nibble = 4'(raw - CH_UA) + HEX_TEN;
            end else if (raw >= CH_LA && raw <= CH_LF) begin
               nibble = 4'(raw - CH_LA) + HEX_TEN;
            end else begin
               is_digit = 1'b0;
            end

            case (escape_state)
               PEND_PERCENT: begin
                  if (is_digit) begin
                     escape_state = PEND_DIGIT;
                     held_digit = raw;
                     held_nibble = nibble;
                  end else begin
                     // A broken escape gives back its percent sign.
                     decoded.push_back(CH_PERCENT);
                     escape_state = PEND_NONE;
                     redo = 1'b1;
                  end
               end
               PEND_DIGIT: begin
                  if (is_digit) begin
                     decoded.push_back({held_nibble, nibble});
                     escape_state = PEND_NONE;
                  end else begin
                     decoded.push_back(CH_PERCENT);
                     decoded.push_back(held_digit);
                     escape_state = PEND_NONE;
                     redo = 1'b1;
                  end
               end
               default: begin
                  escape_state = PEND_NONE;
                  redo = 1'b1;
               end
            endcase

            // The byte is taken on its own when no escape absorbed it.
            if (redo) begin
               if (raw == CH_PERCENT) begin
                  escape_state = PEND_PERCENT;
               end else if (raw == CH_PLUS) begin
                  decoded.push_back(CH_SPACE);
               end else begin
                  decoded.push_back(raw);
               end
            end

            // At the end of the string, anything still held goes out as is.
            if (is_final) begin
               if (escape_state == PEND_PERCENT) begin
                  decoded.push_back(CH_PERCENT);
               end else if (escape_state == PEND_DIGIT) begin
                  decoded.push_back(CH_PERCENT);
                  decoded.push_back(held_digit);
               end
               escape_state = PEND_NONE;
               held_digit = 8'd0;
               held_nibble = 4'd0;
            end

            foreach (decoded[i]) begin
               beat.out_byte = decoded[i];
               beat.run_last = (i == decoded.size() - 1);
               beat.string_end = is_final && (i == decoded.size() - 1);
               due_beats.push_back(beat);
            end
         end

         // Compare an accepted result beat with the oldest one due.
         if (rsp_valid && rsp_ready) begin
            if (due_beats.size() == 0) begin
               $display("%0t: unexpected result beat %02h run_last %b string_end %b",
                        $time, rsp_payload.out_byte, rsp_payload.run_last,
                        rsp_payload.string_end);
               error_count = error_count + 1;
            end else begin
               want = due_beats.pop_front();
               if (rsp_payload.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h, got %02h",
                           $time, want.out_byte, rsp_payload.out_byte);
                  error_count = error_count + 1;
               end
               if (rsp_payload.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %b, got %b",
                           $time, want.run_last, rsp_payload.run_last);
                  error_count = error_count + 1;
               end
               if (rsp_payload.string_end !== want.string_end) begin
                  $display("%0t: string_end expected %b, got %b",
                           $time, want.string_end, rsp_payload.string_end);
                  error_count = error_count + 1;
               end
            end
         end
      end
      results_due = due_beats.size();
   end

endmodule

/* tb/sv/url_percent_decoder_tb.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder_tb: stimulus and verdict for the URL percent decoder
// Sends directed strings covering every escape case, then random strings that
// are mostly well-formed escapes, with random gaps on both channels, a long
// result-side stall and a full drain. Checking is done by upd_decode_checker.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
   import upd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 120;
   localparam int DRAIN_WAIT = 10;

   logic clock = 1'b0;
   logic reset;

   upd_stream_if #(.payload_type(upd_req_type)) req_bus ();
   upd_stream_if #(.payload_type(upd_rsp_type)) rsp_bus ();

   int   error_count;
   int   results_due;
   int   beats_sent = 0;
   int   hold_requests = 0;
   logic calm_sender = 1'b0;
   logic calm_receiver = 1'b0;

   url_percent_decoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   upd_decode_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_payload (req_bus.payload),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_payload (rsp_bus.payload),
      .error_count (error_count),
      .results_due (results_due)
   );

   always #10 clock = ~clock;

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(11, 40);
   endfunction

   // A hex digit character of either case.
   function automatic logic [7:0] hex_char();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) begin
         return 8'(CH_0 + r);
      end else if (r < 16) begin
         return 8'(CH_UA + r - 10);
      end
      return 8'(CH_LA + r - 16);
   endfunction

   // Offer one input beat, after an optional gap, until it is taken.
   task automatic send_beat(input logic [7:0] raw, input logic is_final);
      int          gap;
      upd_req_type beat;
      gap = calm_sender ? 0 : pick_gap();
      beat.in_byte = raw;
      beat.in_last = is_final;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= beat;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   task automatic send_string(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_beat(text[i], i == text.len() - 1);
      end
   endtask

   // A random string: mostly valid escapes, with broken ones and noise.
   task automatic send_random_string();
      logic [7:0] chars[$];
      int         length;
      int         r;
      length = $urandom_range(1, 12);
      while (chars.size() < length) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            chars.push_back(CH_PERCENT);
            chars.push_back(hex_char());
            chars.push_back(hex_char());
         end else if (r < 45) begin
            chars.push_back(CH_PLUS);
         end else if (r < 55) begin
            chars.push_back(CH_PERCENT);
            chars.push_back(8'($urandom_range(0, 255)));
         end else if (r < 62) begin
            chars.push_back(CH_PERCENT);
            chars.push_back(hex_char());
            chars.push_back(8'($urandom_range(0, 255)));
         end else if (r < 70) begin
            chars.push_back(hex_char());
         end else begin
            chars.push_back(8'($urandom_range(0, 255)));
         end
      end
      // Cutting to length may split an escape at the end of the string.
      while (chars.size() > length) void'(chars.pop_back());
      foreach (chars[i]) begin
         send_beat(chars[i], i == chars.size() - 1);
      end
   endtask

   // Stop offering beats and wait until every result due has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
   endtask

   // Result side: random stalls, calm stretches and one long hold-off.
   initial begin : receiver_proc
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm_receiver) stall_left = pick_gap();
         end
      end
   end

   // Watchdog: ends the run when no beat moves for too long.
   initial begin : watchdog_proc
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAIL");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed strings: valid escapes, broken escapes, flushes and extremes.
      send_string("%41");
      send_string("%fF");
      send_string("%G");
      send_string("%%4a");
      send_string("%4Z");
      send_string("%9%");
      send_string("%");
      send_string("%0");
      send_string("%:+");
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);

      // Random strings with gaps on both sides.
      while (beats_sent < 100) send_random_string();

      // Long result-side hold-off while input beats keep coming.
      calm_sender = 1'b1;
      hold_requests++;
      while (beats_sent < 125) send_random_string();
      calm_sender = 1'b0;

      // A stretch with no idling on either side.
      calm_receiver = 1'b1;
      calm_sender = 1'b1;
      while (beats_sent < 165) send_random_string();
      calm_receiver = 1'b0;
      calm_sender = 1'b0;

      // Pause until the decoder has delivered everything, then go on.
      wait_drained();
      while (beats_sent < 225) send_random_string();

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/upd_pkg.sv
rtl/upd_stream_if.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
tb/sv/upd_decode_checker.sv
tb/sv/url_percent_decoder_tb.sv
